/* rtl/cqe_pkg.sv */
// shared types, constants and tables of the quadrature engine
`timescale 1ns / 1ps
package cqe_pkg;

    localparam int MAX_PANELS   = 4096;
    localparam int CORDIC_STEPS = 32;

    localparam logic [12:0] MAX_PANELS_W = 13'(MAX_PANELS);
    localparam logic [5:0]  LAST_STEP    = 6'(CORDIC_STEPS - 1);

    localparam logic signed [63:0] ONE_Q24     = 64'sd16777216;
    localparam logic signed [63:0] K_CIRC      = 64'sd2608131496;
    localparam logic signed [63:0] INV_K_HYP   = 64'sd5186160416;
    localparam logic signed [63:0] PI_Q32      = 64'sd13493037705;
    localparam logic signed [63:0] HALF_PI_Q32 = 64'sd6746518852;
    localparam logic signed [63:0] TWO_PI_Q32  = 64'sd26986075409;
    localparam logic signed [63:0] LN2_Q32     = 64'sd2977044472;
    localparam logic signed [63:0] OUT_MAX     = 64'sd140737488355327;
    localparam logic signed [63:0] OUT_MIN     = -64'sd140737488355328;
    localparam logic [47:0] OUT_MAX48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] OUT_MIN48 = 48'h8000_0000_0000;

    // commands
    localparam logic [1:0] CMD_TRAP  = 2'd0;
    localparam logic [1:0] CMD_SIMP  = 2'd1;
    localparam logic [1:0] CMD_COTES = 2'd2;
    localparam logic [1:0] CMD_INV   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam logic [1:0] ST_INV  = 2'd3;

    // first point of a row
    localparam logic [2:0] SP_A   = 3'd0;
    localparam logic [2:0] SP_H4  = 3'd1;
    localparam logic [2:0] SP_H2  = 3'd2;
    localparam logic [2:0] SP_3H4 = 3'd3;
    localparam logic [2:0] SP_H   = 3'd4;

    // length of a row
    localparam logic [1:0] CN_TWO = 2'd0;
    localparam logic [1:0] CN_N   = 2'd1;
    localparam logic [1:0] CN_N1  = 2'd2;

    // weights
    localparam logic [2:0] WT_1  = 3'd0;
    localparam logic [2:0] WT_2  = 3'd1;
    localparam logic [2:0] WT_4  = 3'd2;
    localparam logic [2:0] WT_7  = 3'd3;
    localparam logic [2:0] WT_12 = 3'd4;
    localparam logic [2:0] WT_14 = 3'd5;
    localparam logic [2:0] WT_32 = 3'd6;

    localparam logic [5:0] SHIFT_F   = 6'd40;
    localparam logic [5:0] SHIFT_INT = 6'd24;

    typedef struct packed {
        logic              start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         shift;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic signed [63:0] value;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic signed [63:0] dividend;
        logic [12:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic signed [63:0] value;
    } div_rsp_t;

    typedef struct packed {
        logic [2:0] start_sel;
        logic [1:0] cnt_sel;
        logic [2:0] wt_sel;
        logic       last;
    } row_desc_t;

    function automatic logic signed [63:0] atan_entry(input logic [5:0] i);
        logic signed [63:0] r;
        case (i)
            6'd0:  r = 64'sd3373259426;
            6'd1:  r = 64'sd1991351318;
            6'd2:  r = 64'sd1052175346;
            6'd3:  r = 64'sd534100635;
            6'd4:  r = 64'sd268086748;
            6'd5:  r = 64'sd134174063;
            6'd6:  r = 64'sd67103403;
            6'd7:  r = 64'sd33553749;
            6'd8:  r = 64'sd16777131;
            6'd9:  r = 64'sd8388597;
            6'd10: r = 64'sd4194303;
            default: r = (i <= 6'd32) ? (64'sd1 <<< (6'd32 - i)) : 64'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] atanh_entry(input logic [5:0] i);
        logic signed [63:0] r;
        case (i)
            6'd0:  r = 64'sd0;
            6'd1:  r = 64'sd2359251925;
            6'd2:  r = 64'sd1096989674;
            6'd3:  r = 64'sd539693625;
            6'd4:  r = 64'sd268785803;
            6'd5:  r = 64'sd134261444;
            6'd6:  r = 64'sd67114326;
            6'd7:  r = 64'sd33555115;
            6'd8:  r = 64'sd16777301;
            6'd9:  r = 64'sd8388619;
            6'd10: r = 64'sd4194305;
            default: r = (i <= 6'd32) ? (64'sd1 <<< (6'd32 - i)) : 64'sd0;
        endcase
        return r;
    endfunction

    // rows of each rule, the first row being the two end points
    function automatic row_desc_t row_desc(input logic [1:0] cmd, input logic [2:0] idx);
        row_desc_t d;
        d = '{SP_A, CN_TWO, WT_1, 1'b1};
        case (cmd)
            CMD_TRAP:
            begin
                case (idx)
                    3'd0:    d = '{SP_A, CN_TWO, WT_1, 1'b0};
                    default: d = '{SP_H, CN_N1, WT_2, 1'b1};
                endcase
            end
            CMD_SIMP:
            begin
                case (idx)
                    3'd0:    d = '{SP_A, CN_TWO, WT_1, 1'b0};
                    3'd1:    d = '{SP_H, CN_N1, WT_2, 1'b0};
                    default: d = '{SP_H2, CN_N, WT_4, 1'b1};
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0:    d = '{SP_A, CN_TWO, WT_7, 1'b0};
                    3'd1:    d = '{SP_H4, CN_N, WT_32, 1'b0};
                    3'd2:    d = '{SP_H2, CN_N, WT_12, 1'b0};
                    3'd3:    d = '{SP_3H4, CN_N, WT_32, 1'b0};
                    default: d = '{SP_H, CN_N1, WT_14, 1'b1};
                endcase
            end
        endcase
        return d;
    endfunction

    function automatic logic signed [63:0] weigh(input logic signed [63:0] s,
                                                 input logic [2:0] wt);
        logic signed [63:0] r;
        case (wt)
            WT_1:    r = s;
            WT_2:    r = s <<< 1;
            WT_4:    r = s <<< 2;
            WT_7:    r = (s <<< 3) - s;
            WT_12:   r = (s <<< 3) + (s <<< 2);
            WT_14:   r = (s <<< 4) - (s <<< 1);
            WT_32:   r = s <<< 5;
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic logic [12:0] rule_div(input logic [1:0] cmd);
        logic [12:0] r;
        case (cmd)
            CMD_TRAP: r = 13'd2;
            CMD_SIMP: r = 13'd6;
            default:  r = 13'd90;
        endcase
        return r;
    endfunction

    // division by a power of two, truncating toward zero
    function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] v,
                                                     input logic [1:0] s);
        logic signed [63:0] r;
        if (v[63])
            r = -((-v) >>> s);
        else
            r = v >>> s;
        return r;
    endfunction

endpackage

/* rtl/cqe_mul.sv */
// sequential shift-add multiplier with scaling and saturation
`timescale 1ns / 1ps
module cqe_mul
    import cqe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_FIN  = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [128:0] prod_reg, prod_next;
    logic [63:0]  ua_reg, ua_next;
    logic         neg_reg, neg_next;
    logic [5:0]   shift_reg, shift_next;
    logic         done_reg, done_next;
    logic signed [63:0] val_reg, val_next;

    logic [64:0]  hi_sum;
    logic [127:0] scaled;
    logic [63:0]  mag;

    always_comb
    begin
        hi_sum = prod_reg[0] ? (prod_reg[128:64] + {1'b0, ua_reg}) : prod_reg[128:64];
        scaled = prod_reg[127:0] >> shift_reg;
        if (scaled[127:63] != '0)
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
        else
            mag = scaled[63:0];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        ua_next    = ua_reg;
        neg_next   = neg_reg;
        shift_next = shift_reg;
        done_next  = 1'b0;
        val_next   = val_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    ua_next    = req.a[63] ? 64'(-req.a) : 64'(req.a);
                    prod_next  = {65'd0, (req.b[63] ? 64'(-req.b) : 64'(req.b))};
                    neg_next   = req.a[63] ^ req.b[63];
                    shift_next = req.shift;
                    cnt_next   = '0;
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                prod_next = {1'b0, hi_sum, prod_reg[63:1]};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = M_FIN;
            end
            M_FIN:
            begin
                val_next   = neg_reg ? -$signed(mag) : $signed(mag);
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        prod_reg  <= prod_next;
        ua_reg    <= ua_next;
        neg_reg   <= neg_next;
        shift_reg <= shift_next;
        val_reg   <= val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

endmodule

/* rtl/cqe_div.sv */
// sequential restoring divider, quotient truncated toward zero
`timescale 1ns / 1ps
module cqe_div
    import cqe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [12:0] rem_reg, rem_next;
    logic [12:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic signed [63:0] val_reg, val_next;

    logic [13:0] rem_s;
    logic [13:0] rem_d;
    logic        fits;

    always_comb
    begin
        rem_s = {rem_reg, q_reg[63]};
        fits  = rem_s >= {1'b0, dvs_reg};
        rem_d = rem_s - {1'b0, dvs_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        val_next   = val_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    q_next     = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
                    neg_next   = req.dividend[63];
                    dvs_next   = req.divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                // remainder stays below the divisor, so 13 bits hold it
                rem_next = fits ? rem_d[12:0] : rem_s[12:0];
                q_next   = {q_reg[62:0], fits};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = D_FIN;
            end
            D_FIN:
            begin
                val_next   = neg_reg ? -$signed(q_reg) : $signed(q_reg);
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        val_reg <= val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

endmodule

/* rtl/cqe_integrand.sv */
// evaluates 1 + exp(-x) * sin(4x) on one shared cordic datapath
`timescale 1ns / 1ps
module cqe_integrand
    import cqe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [63:0] x,
    output logic               f_done,
    output logic signed [63:0] f,
    output mul_req_t           mreq,
    input  mul_rsp_t           mrsp
);

    localparam logic [2:0] I_IDLE   = 3'd0;
    localparam logic [2:0] I_SRED   = 3'd1;
    localparam logic [2:0] I_ROT    = 3'd2;
    localparam logic [2:0] I_ERED   = 3'd3;
    localparam logic [2:0] I_ESHIFT = 3'd4;
    localparam logic [2:0] I_MULQ   = 3'd5;
    localparam logic [2:0] I_MULW   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic signed [63:0] x_reg, x_next;
    logic signed [63:0] cx_reg, cx_next;
    logic signed [63:0] cy_reg, cy_next;
    logic signed [63:0] z_reg, z_next;
    logic signed [63:0] sin_reg, sin_next;
    logic signed [63:0] e_reg, e_next;
    logic signed [63:0] f_reg, f_next;
    logic signed [7:0]  k_reg, k_next;
    logic        hyp_reg, hyp_next;
    logic [5:0]  idx_reg, idx_next;
    logic [5:0]  rep_reg, rep_next;
    logic [5:0]  step_reg, step_next;
    logic        done_reg, done_next;

    logic signed [63:0] sx, sy, ang, rx, ry, rz, zz, zf;
    logic signed [7:0]  kc, kn;
    logic        dir;

    // one cordic micro-rotation, circular or hyperbolic
    always_comb
    begin
        sx  = cy_reg >>> idx_reg;
        sy  = cx_reg >>> idx_reg;
        ang = hyp_reg ? atanh_entry(idx_reg) : atan_entry(idx_reg);
        dir = !z_reg[63];
        rx  = (dir ^ hyp_reg) ? (cx_reg - sx) : (cx_reg + sx);
        ry  = dir ? (cy_reg + sy) : (cy_reg - sy);
        rz  = dir ? (z_reg - ang) : (z_reg + ang);
    end

    always_comb
    begin
        zz = z_reg - PI_Q32;
        if (zz > HALF_PI_Q32)
            zf = PI_Q32 - zz;
        else if (zz < -HALF_PI_Q32)
            zf = -PI_Q32 - zz;
        else
            zf = zz;
        if (k_reg > 8'sd20)
            kc = 8'sd20;
        else if (k_reg < -8'sd63)
            kc = -8'sd63;
        else
            kc = k_reg;
        kn = -kc;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        z_next     = z_reg;
        sin_next   = sin_reg;
        e_next     = e_reg;
        f_next     = f_reg;
        k_next     = k_reg;
        hyp_next   = hyp_reg;
        idx_next   = idx_reg;
        rep_next   = rep_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        case (state_reg)
            I_IDLE:
            begin
                if (go)
                begin
                    x_next     = x;
                    z_next     = (x <<< 2) + PI_Q32;
                    state_next = I_SRED;
                end
            end
            I_SRED:
            begin
                // bring 4x + pi into one turn, one add a beat
                if (z_reg >= TWO_PI_Q32)
                    z_next = z_reg - TWO_PI_Q32;
                else if (z_reg[63])
                    z_next = z_reg + TWO_PI_Q32;
                else
                begin
                    z_next     = zf;
                    cx_next    = K_CIRC;
                    cy_next    = '0;
                    hyp_next   = 1'b0;
                    idx_next   = '0;
                    step_next  = '0;
                    state_next = I_ROT;
                end
            end
            I_ROT:
            begin
                cx_next   = rx;
                cy_next   = ry;
                z_next    = rz;
                step_next = step_reg + 6'd1;
                if (hyp_reg)
                begin
                    if ((idx_reg == 6'd4 || idx_reg == 6'd13 || idx_reg == 6'd40)
                        && rep_reg != idx_reg)
                        rep_next = idx_reg;
                    else
                        idx_next = idx_reg + 6'd1;
                end
                else
                    idx_next = idx_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    if (hyp_reg)
                    begin
                        e_next     = rx + ry;
                        state_next = I_ESHIFT;
                    end
                    else
                    begin
                        sin_next   = ry;
                        z_next     = -x_reg;
                        k_next     = '0;
                        state_next = I_ERED;
                    end
                end
            end
            I_ERED:
            begin
                // split -x into k*ln2 + r with r in [0, ln2)
                if (z_reg >= LN2_Q32)
                begin
                    z_next = z_reg - LN2_Q32;
                    k_next = k_reg + 8'sd1;
                end
                else if (z_reg[63])
                begin
                    z_next = z_reg + LN2_Q32;
                    k_next = k_reg - 8'sd1;
                end
                else
                begin
                    cx_next    = INV_K_HYP;
                    cy_next    = '0;
                    hyp_next   = 1'b1;
                    idx_next   = 6'd1;
                    rep_next   = '0;
                    step_next  = '0;
                    state_next = I_ROT;
                end
            end
            I_ESHIFT:
            begin
                if (kc[7])
                    e_next = e_reg >>> kn[5:0];
                else
                    e_next = e_reg <<< kc[5:0];
                state_next = I_MULQ;
            end
            I_MULQ:
            begin
                state_next = I_MULW;
            end
            I_MULW:
            begin
                if (mrsp.done)
                begin
                    f_next     = ONE_Q24 + mrsp.value;
                    done_next  = 1'b1;
                    state_next = I_IDLE;
                end
            end
            default:
            begin
                state_next = I_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        z_reg    <= z_next;
        sin_reg  <= sin_next;
        e_reg    <= e_next;
        f_reg    <= f_next;
        k_reg    <= k_next;
        hyp_reg  <= hyp_next;
        idx_reg  <= idx_next;
        rep_reg  <= rep_next;
        step_reg <= step_next;
    end

    assign mreq.start = (state_reg == I_MULQ);
    assign mreq.a     = e_reg;
    assign mreq.b     = sin_reg;
    assign mreq.shift = SHIFT_F;
    assign f_done     = done_reg;
    assign f          = f_reg;

endmodule

/* rtl/composite_quadrature_engine.sv */
// composite newton-cotes quadrature engine: rule sequencer and output stage
// order of work: a division for the step, then for each integrand sample a reduction,
// 64 cordic steps and a multiply, then a multiply and a division for the final scaling
// samples per item: 2 + (n-1) trapezoid, 2n+1 simpson, 4n+1 cotes; one item at a time,
// busy high while it runs; invalid rule or zero panels are answered in the next cycle,
// busy low; asynchronous active-low reset returns to idle; each result is a one-cycle done strobe
`timescale 1ns / 1ps
module composite_quadrature_engine
    import cqe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [31:0] lower_limit,
    input  logic signed [31:0] upper_limit,
    input  logic [12:0]        panel_count,
    output logic               done,
    output logic signed [47:0] integral,
    output logic [1:0]         status
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVH  = 4'd1;
    localparam logic [3:0] S_DIVHW = 4'd2;
    localparam logic [3:0] S_SINIT = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_EVALW = 4'd5;
    localparam logic [3:0] S_SNEXT = 4'd6;
    localparam logic [3:0] S_FMUL  = 4'd7;
    localparam logic [3:0] S_FMULW = 4'd8;
    localparam logic [3:0] S_FDIV  = 4'd9;
    localparam logic [3:0] S_FDIVW = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic signed [63:0] a_reg, a_next;
    logic signed [63:0] b_reg, b_next;
    logic [12:0] n_reg, n_next;
    logic signed [63:0] h_reg, h_next;
    logic signed [63:0] w_reg, w_next;
    logic signed [63:0] sum_reg, sum_next;
    logic signed [63:0] x_reg, x_next;
    logic signed [63:0] step_reg, step_next;
    logic signed [63:0] mres_reg, mres_next;
    logic [12:0] left_reg, left_next;
    logic [2:0]  row_reg, row_next;
    logic        done_reg, done_next;
    logic signed [47:0] integral_reg, integral_next;
    logic [1:0]  status_reg, status_next;

    row_desc_t   desc;
    logic signed [63:0] x0, h3;
    logic [12:0] cnt0;
    logic        accept;

    mul_req_t    int_mreq, mreq;
    mul_rsp_t    mrsp;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        f_done;
    logic signed [63:0] f_val;

    cqe_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    cqe_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    cqe_integrand u_fx
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (state_reg == S_EVAL),
        .x      (x_reg),
        .f_done (f_done),
        .f      (f_val),
        .mreq   (int_mreq),
        .mrsp   (mrsp)
    );

    // multiplier is shared: final scaling only while the sequencer owns it
    always_comb
    begin
        if (state_reg == S_FMUL || state_reg == S_FMULW)
        begin
            mreq.start = (state_reg == S_FMUL);
            mreq.a     = h_reg;
            mreq.b     = w_reg;
            mreq.shift = SHIFT_INT;
        end
        else
            mreq = int_mreq;
        dreq.start    = (state_reg == S_DIVH) || (state_reg == S_FDIV);
        dreq.dividend = (state_reg == S_FDIV) ? mres_reg : (b_reg - a_reg);
        dreq.divisor  = (state_reg == S_FDIV) ? rule_div(cmd_reg) : n_reg;
    end

    always_comb
    begin
        desc = row_desc(cmd_reg, row_reg);
        h3   = h_reg + (h_reg <<< 1);
        case (desc.start_sel)
            SP_A:    x0 = a_reg;
            SP_H4:   x0 = a_reg + tdiv_pow2(h_reg, 2'd2);
            SP_H2:   x0 = a_reg + tdiv_pow2(h_reg, 2'd1);
            SP_3H4:  x0 = a_reg + tdiv_pow2(h3, 2'd2);
            default: x0 = a_reg + h_reg;
        endcase
        case (desc.cnt_sel)
            CN_TWO:  cnt0 = 13'd2;
            CN_N:    cnt0 = n_reg;
            default: cnt0 = n_reg - 13'd1;
        endcase
    end

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        n_next        = n_reg;
        h_next        = h_reg;
        w_next        = w_reg;
        sum_next      = sum_reg;
        x_next        = x_reg;
        step_next     = step_reg;
        mres_next     = mres_reg;
        left_next     = left_reg;
        row_next      = row_reg;
        done_next     = 1'b0;
        integral_next = integral_reg;
        status_next   = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    a_next   = {{28{lower_limit[31]}}, lower_limit, 4'd0};
                    b_next   = {{28{upper_limit[31]}}, upper_limit, 4'd0};
                    n_next   = (panel_count > MAX_PANELS_W) ? MAX_PANELS_W : panel_count;
                    w_next   = '0;
                    row_next = '0;
                    if (command == CMD_INV)
                    begin
                        integral_next = '0;
                        status_next   = ST_INV;
                        done_next     = 1'b1;
                    end
                    else if (panel_count == '0)
                    begin
                        integral_next = '0;
                        status_next   = ST_ZERO;
                        done_next     = 1'b1;
                    end
                    else
                        state_next = S_DIVH;
                end
            end
            S_DIVH:
            begin
                state_next = S_DIVHW;
            end
            S_DIVHW:
            begin
                if (drsp.done)
                begin
                    h_next     = drsp.value;
                    state_next = S_SINIT;
                end
            end
            S_SINIT:
            begin
                // the end-point row steps by b - a so its second sample is b itself
                x_next    = x0;
                step_next = (desc.cnt_sel == CN_TWO) ? (b_reg - a_reg) : h_reg;
                left_next = cnt0;
                sum_next  = '0;
                if (cnt0 == '0)
                    state_next = S_SNEXT;
                else
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_EVALW;
            end
            S_EVALW:
            begin
                if (f_done)
                begin
                    sum_next  = sum_reg + f_val;
                    x_next    = x_reg + step_reg;
                    left_next = left_reg - 13'd1;
                    if (left_reg == 13'd1)
                        state_next = S_SNEXT;
                    else
                        state_next = S_EVAL;
                end
            end
            S_SNEXT:
            begin
                w_next = w_reg + weigh(sum_reg, desc.wt_sel);
                if (desc.last)
                    state_next = S_FMUL;
                else
                begin
                    row_next   = row_reg + 3'd1;
                    state_next = S_SINIT;
                end
            end
            S_FMUL:
            begin
                state_next = S_FMULW;
            end
            S_FMULW:
            begin
                if (mrsp.done)
                begin
                    mres_next  = mrsp.value;
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                state_next = S_FDIVW;
            end
            S_FDIVW:
            begin
                if (drsp.done)
                begin
                    if (drsp.value > OUT_MAX)
                    begin
                        integral_next = OUT_MAX48;
                        status_next   = ST_SAT;
                    end
                    else if (drsp.value < OUT_MIN)
                    begin
                        integral_next = OUT_MIN48;
                        status_next   = ST_SAT;
                    end
                    else
                    begin
                        integral_next = drsp.value[47:0];
                        status_next   = ST_OK;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        n_reg        <= n_next;
        h_reg        <= h_next;
        w_reg        <= w_next;
        sum_reg      <= sum_next;
        x_reg        <= x_next;
        step_reg     <= step_next;
        mres_reg     <= mres_next;
        left_reg     <= left_next;
        row_reg      <= row_next;
        integral_reg <= integral_next;
        status_reg   <= status_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign integral = integral_reg;
    assign status   = status_reg;

    a_inv_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_INV) |=> (done && status == ST_INV && integral == '0))
        else $error("invalid rule not answered at once");

    a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command != CMD_INV && panel_count == '0)
        |=> (done && status == ST_ZERO))
        else $error("zero panel count not flagged");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_SAT) |-> (integral == OUT_MAX48 || integral == OUT_MIN48))
        else $error("saturated result not at a bound");

    a_panels: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (n_reg != '0 && n_reg <= MAX_PANELS_W))
        else $error("panel count out of range while busy");

endmodule

/* verif/tb_composite_quadrature_engine.sv */
// self-checking testbench of the composite quadrature engine
`timescale 1ns / 1ps
module tb_composite_quadrature_engine;
    import cqe_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic [12:0]        panel_count;
    logic               done;
    logic signed [47:0] integral;
    logic [1:0]         status;

    int mismatches = 0;

    composite_quadrature_engine dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .lower_limit(lower_limit), .upper_limit(upper_limit),
        .panel_count(panel_count), .done(done), .integral(integral), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // ---------------- fixed-point integrand ----------------
    function automatic longint arith_shift(input longint v, input int s);
        return v >>> (s & 63);
    endfunction

    function automatic longint floored_div(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // exact product, magnitude truncated and clamped to 63 bits
    function automatic longint scaled_product(input longint a, input longint b, input int s);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        longint       q;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
        ub = (b < 0) ? 64'd0 - 64'(b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        p = p >> (s & 63);
        if (p > 128'h7FFF_FFFF_FFFF_FFFF)
            q = 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            q = longint'(p[63:0]);
        return neg ? -q : q;
    endfunction

    function automatic longint circ_angle(input int i);
        longint t[11];
        t = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
              64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
              64'sd16777131, 64'sd8388597, 64'sd4194303};
        if (i <= 10)
            return t[i];
        return (i <= 32) ? (64'sd1 <<< (32 - i)) : 64'sd0;
    endfunction

    function automatic longint hyp_angle(input int i);
        longint t[11];
        t = '{64'sd0, 64'sd2359251925, 64'sd1096989674, 64'sd539693625,
              64'sd268785803, 64'sd134261444, 64'sd67114326, 64'sd33555115,
              64'sd16777301, 64'sd8388619, 64'sd4194305};
        if (i <= 10)
            return t[i];
        return (i <= 32) ? (64'sd1 <<< (32 - i)) : 64'sd0;
    endfunction

    function automatic longint sine_q32(input longint t);
        longint k;
        longint z;
        longint cx;
        longint cy;
        longint nx;
        k = floored_div(t + PI_Q32, TWO_PI_Q32);
        z = t - k * TWO_PI_Q32;
        cx = K_CIRC;
        cy = 0;
        if (z > HALF_PI_Q32)
            z = PI_Q32 - z;
        else if (z < -HALF_PI_Q32)
            z = -PI_Q32 - z;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = cx - arith_shift(cy, i);
                cy = cy + arith_shift(cx, i);
                z = z - circ_angle(i);
            end
            else
            begin
                nx = cx + arith_shift(cy, i);
                cy = cy - arith_shift(cx, i);
                z = z + circ_angle(i);
            end
            cx = nx;
        end
        return cy;
    endfunction

    function automatic longint exp_q32(input longint u);
        longint k;
        longint z;
        longint cx;
        longint cy;
        longint nx;
        longint e;
        int     i;
        int     last_rep;
        k = floored_div(u, LN2_Q32);
        z = u - k * LN2_Q32;
        cx = INV_K_HYP;
        cy = 0;
        i = 1;
        last_rep = 0;
        for (int step = 0; step < CORDIC_STEPS; step++)
        begin
            if (z >= 0)
            begin
                nx = cx + arith_shift(cy, i);
                cy = cy + arith_shift(cx, i);
                z = z - hyp_angle(i);
            end
            else
            begin
                nx = cx - arith_shift(cy, i);
                cy = cy - arith_shift(cx, i);
                z = z + hyp_angle(i);
            end
            cx = nx;
            // indices 4, 13 and 40 are repeated once
            if ((i == 4 || i == 13 || i == 40) && last_rep != i)
                last_rep = i;
            else
                i++;
        end
        e = cx + cy;
        if (k > 20)
            k = 20;
        if (k < -63)
            k = -63;
        return (k >= 0) ? e * (64'sd1 <<< k) : arith_shift(e, int'(-k));
    endfunction

    function automatic longint integrand_q24(input longint x);
        return ONE_Q24 + scaled_product(exp_q32(-x), sine_q32(4 * x), 40);
    endfunction

    function automatic longint row_sum(input longint first, input longint h, input longint count);
        longint acc;
        longint x;
        acc = 0;
        x = first;
        for (longint i = 0; i < count; i++)
        begin
            acc = acc + integrand_q24(x);
            x = x + h;
        end
        return acc;
    endfunction

    typedef struct {
        logic signed [47:0] integral;
        logic [1:0]         status;
    } estimate_t;

    function automatic estimate_t predict_estimate(input logic [1:0] cmd,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi,
                                                   input logic [12:0] n_in);
        estimate_t r;
        longint    a;
        longint    b;
        longint    n;
        longint    h;
        longint    fa;
        longint    fb;
        longint    w;
        longint    d;
        longint    v;
        a = longint'(lo) * 16;
        b = longint'(hi) * 16;
        n = longint'(n_in);
        v = 0;
        r.status = ST_OK;
        if (cmd == CMD_INV)
            r.status = ST_INV;
        else if (n == 0)
            r.status = ST_ZERO;
        else
        begin
            if (n > MAX_PANELS)
                n = MAX_PANELS;
            h = (b - a) / n;
            fa = integrand_q24(a);
            fb = integrand_q24(b);
            if (cmd == CMD_TRAP)
            begin
                w = 2 * row_sum(a + h, h, n - 1) + fa + fb;
                d = 2;
            end
            else if (cmd == CMD_SIMP)
            begin
                w = fa + fb + 2 * row_sum(a + h, h, n - 1) + 4 * row_sum(a + h / 2, h, n);
                d = 6;
            end
            else
            begin
                w = 7 * fa + 32 * row_sum(a + h / 4, h, n) + 12 * row_sum(a + h / 2, h, n)
                    + 32 * row_sum(a + (3 * h) / 4, h, n) + 14 * row_sum(a + h, h, n - 1)
                    + 7 * fb;
                d = 90;
            end
            v = scaled_product(h, w, 24) / d;
            if (v > OUT_MAX)
            begin
                v = OUT_MAX;
                r.status = ST_SAT;
            end
            else if (v < OUT_MIN)
            begin
                v = OUT_MIN;
                r.status = ST_SAT;
            end
        end
        r.integral = v[47:0];
        return r;
    endfunction

    class estimate_board;
        estimate_t pending[$];

        function void note_request(logic [1:0] cmd, logic signed [31:0] lo,
                                   logic signed [31:0] hi, logic [12:0] n);
            pending.push_back(predict_estimate(cmd, lo, hi, n));
        endfunction

        task check_result(logic signed [47:0] got_int, logic [1:0] got_st);
            estimate_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result", got_int, 0);
                return;
            end
            e = pending.pop_front();
            if (got_int !== e.integral)
                report("integral", got_int, e.integral);
            if (got_st !== e.status)
                report("status", got_st, e.status);
        endtask
    endclass

    estimate_board board = new();

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(integral, status);
    end

    // present one command beat and hold it until accepted
    task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] lo,
                                input logic signed [31:0] hi, input logic [12:0] n,
                                input bit may_idle);
        int gap;
        start <= 1'b1;
        command <= cmd;
        lower_limit <= lo;
        upper_limit <= hi;
        panel_count <= n;
        do
            @(posedge clk);
        while (busy);
        board.note_request(cmd, lo, hi, n);
        if (may_idle && $urandom_range(99) < 19)
        begin
            gap = $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(input bit may_idle);
        logic [1:0]         cmd;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [12:0]        n;
        int                 pick;
        pick = $urandom_range(99);
        cmd = (pick < 8) ? CMD_INV : 2'($urandom_range(2));
        if ($urandom_range(3) == 0)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else
        begin
            lo = $signed(32'($urandom_range(32'h3000_0000))) - 32'sh1800_0000;
            hi = $signed(32'($urandom_range(32'h3000_0000))) - 32'sh1800_0000;
        end
        pick = $urandom_range(99);
        if (cmd == CMD_INV)
            n = 13'($urandom);
        else if (pick < 6)
            n = 13'd0;
        else if (pick < 92)
            n = 13'($urandom_range(6, 1));
        else
            n = 13'($urandom_range(40, 7));
        send_request(cmd, lo, hi, n, may_idle);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_TRAP;
        lower_limit = '0;
        upper_limit = '0;
        panel_count = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats: each rule, the limits at their extremes, error cases
        send_request(CMD_TRAP,  32'sh0000_0000, 32'sh1000_0000, 13'd1, 1'b1);
        send_request(CMD_SIMP,  32'sh0000_0000, 32'sh1000_0000, 13'd2, 1'b1);
        send_request(CMD_COTES, 32'sh0000_0000, 32'sh1000_0000, 13'd3, 1'b1);
        send_request(CMD_INV,   32'sh8000_0000, 32'sh7FFF_FFFF, 13'h1FFF, 1'b1);
        send_request(CMD_INV,   32'sh7FFF_FFFF, 32'sh8000_0000, 13'd0, 1'b1);
        send_request(CMD_TRAP,  32'sh0000_0000, 32'sh1000_0000, 13'd0, 1'b1);
        send_request(CMD_SIMP,  32'sh8000_0000, 32'sh7FFF_FFFF, 13'd0, 1'b1);
        send_request(CMD_COTES, 32'sh1000_0000, 32'sh2000_0000, 13'd0, 1'b1);
        send_request(CMD_TRAP,  32'sh8000_0000, 32'sh7FFF_FFFF, 13'd1, 1'b1);
        send_request(CMD_SIMP,  32'sh8000_0000, 32'sh7FFF_FFFF, 13'd1, 1'b1);
        send_request(CMD_COTES, 32'sh8000_0000, 32'sh7FFF_FFFF, 13'd2, 1'b1);
        send_request(CMD_COTES, 32'sh7FFF_FFFF, 32'sh8000_0000, 13'd2, 1'b1);
        send_request(CMD_SIMP,  32'sh8000_0000, 32'sh8000_0000, 13'd4, 1'b1);
        send_request(CMD_TRAP,  32'sh2000_0000, 32'shE000_0000, 13'd5, 1'b1);
        send_request(CMD_COTES, 32'sh8000_0000, 32'shA000_0000, 13'd1, 1'b1);
        send_request(CMD_SIMP,  32'sh0000_0001, 32'shFFFF_FFFF, 13'd3, 1'b1);
        // panel count above the maximum is clamped
        send_request(CMD_TRAP,  32'shF000_0000, 32'sh1000_0000, 13'h1FFF, 1'b1);
        send_request(CMD_INV,   32'sh5555_5555, 32'shAAAA_AAAA, 13'h0AAA, 1'b1);

        for (int k = 0; k < 100; k++)
            send_random(!(k >= 40 && k < 70));
        start <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #150_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
